// ===== rtl/zct_pkg.sv =====
// ----------------------------------------------------------------------------
// zct_pkg
// Shared widths, term codes and per-term coefficient tables for the
// Cartesian Zernike term evaluator.
// ----------------------------------------------------------------------------
package zct_pkg;

    localparam int QFRAC  = 32;   // internal fraction bits
    localparam int FW     = 38;   // width of coordinates, powers and factors
    localparam int HW     = 58;   // width of radial accumulators and results
    localparam int CW     = 18;   // coefficient width
    localparam int NCOEF  = 9;    // Horner taps, highest degree first
    localparam int OP_W   = 6;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 48;
    localparam int INPUT_FRAC_BITS_DEF = 23;

    typedef enum logic [5:0] {
        ZT_00 = 6'd0, ZT_01, ZT_02, ZT_03, ZT_04, ZT_05, ZT_06, ZT_07,
        ZT_08, ZT_09, ZT_10, ZT_11, ZT_12, ZT_13, ZT_14, ZT_15,
        ZT_16, ZT_17, ZT_18, ZT_19, ZT_20, ZT_21, ZT_22, ZT_23,
        ZT_24, ZT_25, ZT_26, ZT_27, ZT_28, ZT_29, ZT_30, ZT_31,
        ZT_32, ZT_33, ZT_34, ZT_35, ZT_36, ZT_37, ZT_38, ZT_39,
        ZT_40, ZT_41
    } term_t;

    // angular factor that multiplies the radial polynomial
    typedef enum logic [3:0] {
        F_ONE, F_X, F_Y, F_DXY, F_XY, F_XY2, F_C3, F_S3,
        F_C4, F_S4, F_C5, F_S5, F_T36, F_T37
    } factor_t;

    typedef logic [0:NCOEF-1][CW-1:0] coef_row_t;

    typedef struct packed {
        factor_t   fsel;
        coef_row_t coefs;
    } term_info_t;

    // right-aligns n coefficients, leading taps are zero
    function automatic coef_row_t crow(input int n, input int a0 = 0,
                                       input int a1 = 0, input int a2 = 0,
                                       input int a3 = 0, input int a4 = 0,
                                       input int a5 = 0, input int a6 = 0,
                                       input int a7 = 0, input int a8 = 0);
        int        a [NCOEF];
        int        off;
        coef_row_t r;
        a   = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
        off = NCOEF - n;
        for (int i = 0; i < NCOEF; i++) begin
            if (i >= off) begin
                r[i] = CW'(a[i - off]);
            end else begin
                r[i] = '0;
            end
        end
        return r;
    endfunction

    function automatic term_info_t term_info(input logic [OP_W-1:0] op);
        term_info_t t;
        t.fsel  = F_ONE;
        t.coefs = '0;
        case (term_t'(op))
            ZT_00: begin t.fsel = F_ONE; t.coefs = crow(1, 1); end
            ZT_01: begin t.fsel = F_X;   t.coefs = crow(1, 1); end
            ZT_02: begin t.fsel = F_Y;   t.coefs = crow(1, 1); end
            ZT_03: begin t.fsel = F_ONE; t.coefs = crow(2, 2, -1); end
            ZT_04: begin t.fsel = F_DXY; t.coefs = crow(1, 1); end
            ZT_05: begin t.fsel = F_XY2; t.coefs = crow(1, 1); end
            ZT_06: begin t.fsel = F_X;   t.coefs = crow(2, 3, -2); end
            ZT_07: begin t.fsel = F_Y;   t.coefs = crow(2, 3, -2); end
            ZT_08: begin t.fsel = F_ONE; t.coefs = crow(3, 6, -6, 1); end
            ZT_09: begin t.fsel = F_C3;  t.coefs = crow(1, 1); end
            ZT_10: begin t.fsel = F_S3;  t.coefs = crow(1, 1); end
            ZT_11: begin t.fsel = F_DXY; t.coefs = crow(2, 4, -3); end
            ZT_12: begin t.fsel = F_XY2; t.coefs = crow(2, 4, -3); end
            ZT_13: begin t.fsel = F_X;   t.coefs = crow(3, 10, -12, 3); end
            ZT_14: begin t.fsel = F_Y;   t.coefs = crow(3, 10, -12, 3); end
            ZT_15: begin t.fsel = F_ONE; t.coefs = crow(4, 20, -30, 12, -1); end
            ZT_16: begin t.fsel = F_C4;  t.coefs = crow(1, 1); end
            ZT_17: begin t.fsel = F_S4;  t.coefs = crow(1, 1); end
            ZT_18: begin t.fsel = F_C3;  t.coefs = crow(2, 5, -4); end
            ZT_19: begin t.fsel = F_S3;  t.coefs = crow(2, 5, -4); end
            ZT_20: begin t.fsel = F_DXY; t.coefs = crow(3, 15, -20, 6); end
            ZT_21: begin t.fsel = F_XY2; t.coefs = crow(3, 15, -20, 6); end
            ZT_22: begin t.fsel = F_X;   t.coefs = crow(4, 35, -60, 30, -4); end
            ZT_23: begin t.fsel = F_Y;   t.coefs = crow(4, 35, -60, 30, -4); end
            ZT_24: begin
                t.fsel  = F_ONE;
                t.coefs = crow(5, 70, -140, 90, -20, 1);
            end
            ZT_25: begin t.fsel = F_C5;  t.coefs = crow(1, 1); end
            ZT_26: begin t.fsel = F_S5;  t.coefs = crow(1, 1); end
            ZT_27: begin t.fsel = F_C4;  t.coefs = crow(2, 6, -5); end
            ZT_28: begin t.fsel = F_S4;  t.coefs = crow(2, 6, -5); end
            ZT_29: begin t.fsel = F_C3;  t.coefs = crow(3, 21, -30, 10); end
            ZT_30: begin t.fsel = F_S3;  t.coefs = crow(3, 21, -30, 10); end
            ZT_31: begin
                t.fsel  = F_DXY;
                t.coefs = crow(4, 56, -105, 60, -10);
            end
            ZT_32: begin
                t.fsel  = F_XY;
                t.coefs = crow(4, 112, -210, 120, -20);
            end
            ZT_33: begin
                t.fsel  = F_X;
                t.coefs = crow(5, 126, -280, 210, -60, 5);
            end
            ZT_34: begin
                t.fsel  = F_Y;
                t.coefs = crow(5, 126, -280, 210, -60, 5);
            end
            ZT_35: begin
                t.fsel  = F_ONE;
                t.coefs = crow(6, 252, -630, 560, -210, 30, -1);
            end
            ZT_36: begin t.fsel = F_T36; t.coefs = crow(1, 1); end
            ZT_37: begin t.fsel = F_T37; t.coefs = crow(1, 1); end
            ZT_38: begin t.fsel = F_C5;  t.coefs = crow(2, 7, -6); end
            ZT_39: begin
                t.fsel  = F_ONE;
                t.coefs = crow(7, 924, -2772, 3150, -1680, 420, -42, 1);
            end
            ZT_40: begin
                t.fsel  = F_ONE;
                t.coefs = crow(8, 3432, -12012, 16632, -11550, 4200, -756,
                               56, -1);
            end
            ZT_41: begin
                t.fsel  = F_ONE;
                t.coefs = crow(9, 12870, -51480, 84084, -72072, 34650,
                               -9240, 1260, -72, 1);
            end
            default: begin
                t.fsel  = F_ONE;
                t.coefs = '0;
            end
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/zct_qmul.sv =====
// ----------------------------------------------------------------------------
// zct_qmul
// Two-stage fixed-point multiplier: round(a * b / 2^32), ties up.
// ----------------------------------------------------------------------------
module zct_qmul #(
    parameter int AW = 38,
    parameter int BW = 38,
    parameter int OW = 38
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [OW-1:0] p
);
    import zct_pkg::*;

    localparam int LW = BW / 2;
    localparam int UW = BW - LW;
    localparam int SW = AW + BW + 1;
    localparam logic signed [SW-1:0] RND =
        {{(SW - QFRAC){1'b0}}, 1'b1, {(QFRAC - 1){1'b0}}};

    logic signed [AW+LW:0]   lo_reg, lo_next;
    logic signed [AW+UW-1:0] hi_reg, hi_next;
    logic signed [SW-1:0]    sum;
    logic signed [OW-1:0]    p_reg, p_next;

    // stage 1: split b, two partial products
    always_comb begin
        lo_next = a * $signed({1'b0, b[LW-1:0]});
        hi_next = a * $signed(b[BW-1:LW]);
    end

    // stage 2: recombine, round, scale
    always_comb begin
        sum    = (SW'(hi_reg) <<< LW) + SW'(lo_reg) + RND;
        p_next = sum[OW+QFRAC-1:QFRAC];
    end

    always_ff @(posedge clk) begin
        if (en) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/zernike_cartesian_term_eval.sv =====
// ----------------------------------------------------------------------------
// zernike_cartesian_term_eval
// Evaluates one Zernike term (0..41) at a pupil point per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries a term number and a point
//   (x_coord, y_coord) in signed Q1.INPUT_FRAC_BITS. Output channel
//   (out_valid/out_ready) returns the term value in Q24.24 plus a
//   saturation flag. Term numbers above 41 return zero.
// Throughput: one transaction per cycle while the skid entry is empty, fully pipelined.
// Datapath: each term is factor(x, y) * R(r2); R is a 9-tap Horner chain
//   in r2 with a two-stage multiplier between consecutive taps, and that
//   chain sets the depth.
// Stall: a two-entry output stage (output register plus skid) decouples
//   the sides; the pipeline advances while the skid entry is empty, so an
//   input is still taken while one finished result waits.
// Reset: clears all valid bits; no other state. No transaction is lost
//   or repeated across a receiver stall.
// ----------------------------------------------------------------------------
module zernike_cartesian_term_eval #(
    parameter int INPUT_FRAC_BITS = zct_pkg::INPUT_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [zct_pkg::OP_W-1:0]           opcode,
    input  logic signed [zct_pkg::IN_W-1:0]    x_coord,
    input  logic signed [zct_pkg::IN_W-1:0]    y_coord,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [zct_pkg::OUT_W-1:0]   term_value,
    output logic                               saturated
);
    import zct_pkg::*;

    localparam int SHW = QFRAC - INPUT_FRAC_BITS;
    localparam int EW  = (IN_W + SHW > FW) ? IN_W + SHW : FW;
    localparam int RW  = HW - 8;   // width after Q32 -> Q24
    localparam logic signed [RW-1:0] OMAX = RW'({1'b0, {(OUT_W - 1){1'b1}}});
    localparam logic signed [RW-1:0] OMIN = ~OMAX;
    localparam logic signed [HW-1:0] HALF8 = HW'(128);

    // scale to Q32 and clamp to [-1, 1]
    function automatic logic signed [FW-1:0] to_q(input logic signed [IN_W-1:0] raw);
        logic signed [EW-1:0] w;
        logic signed [EW-1:0] one_c;
        w     = EW'(raw) <<< SHW;
        one_c = EW'(1) <<< QFRAC;
        if (w > one_c) begin
            w = one_c;
        end else if (w < -one_c) begin
            w = -one_c;
        end
        return FW'(w);
    endfunction

    // pipeline enable: stall only when the skid entry is occupied
    logic en;

    logic [OP_W-1:0]     op_reg  [0:18];
    logic                vld_reg [0:21];
    logic signed [FW-1:0] x_reg  [0:6];
    logic signed [FW-1:0] y_reg  [0:6];

    // level 1 outputs (t2) and derived
    logic signed [FW-1:0] x2_t2, y2_t2, xy_t2, r2_t2, dxy_t2;
    logic signed [FW-1:0] x2_reg [3:4];
    logic signed [FW-1:0] y2_reg [3:4];
    logic signed [FW-1:0] xy_reg [3:6];
    logic signed [FW-1:0] dxy_reg [3:6];
    logic signed [FW-1:0] r2_reg [3:16];

    // level 2 outputs (t4)
    logic signed [FW-1:0] x3_t4, y3_t4, x4_t4, y4_t4, x2y2_t4;
    logic signed [FW-1:0] xy2_t4, x2y_t4, s4p_t4;
    logic signed [FW-1:0] c3_t4, s3_t4, c4_t4, s4_t4, q5c_t4, q5s_t4, q37_t4;
    logic signed [FW-1:0] c3_reg [5:6];
    logic signed [FW-1:0] s3_reg [5:6];
    logic signed [FW-1:0] c4_reg [5:6];
    logic signed [FW-1:0] s4_reg [5:6];

    // level 3 outputs (t6)
    logic signed [FW-1:0] c5_t6, s5_t6, t37_t6, pa_t6, pb_t6, pc_t6, pd_t6;
    logic signed [FW-1:0] t36_t6, f_next;
    term_info_t           ti6;
    logic signed [FW-1:0] f_reg [7:18];

    // radial chain
    logic signed [HW-1:0] hq [1:8];
    logic signed [HW-1:0] acc8;
    term_info_t           ti18;
    logic signed [HW-1:0] v_t20;

    // rounding and saturation (t21)
    logic signed [HW-1:0] vr;
    logic signed [RW-1:0] rs;
    logic signed [OUT_W-1:0] res_reg, res_next;
    logic                 sat_reg, sat_next;

    // output stage
    logic                    out_valid_reg, out_valid_next;
    logic                    skid_valid_reg, skid_valid_next;
    logic signed [OUT_W-1:0] tv_reg, skid_tv_reg;
    logic                    st_reg, skid_st_reg;
    logic                    load_out_pipe, load_out_skid, load_skid;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // control: valid bits and term number travel with the data
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i <= 21; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= 21; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            op_reg[0] <= opcode;
            x_reg[0]  <= to_q(x_coord);
            y_reg[0]  <= to_q(y_coord);
            for (int i = 1; i <= 18; i++) begin
                op_reg[i] <= op_reg[i-1];
            end
            for (int i = 1; i <= 6; i++) begin
                x_reg[i] <= x_reg[i-1];
                y_reg[i] <= y_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // level 1: squares and cross product
    // ------------------------------------------------------------------
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_x2 (
        .clk(clk), .en(en), .a(x_reg[0]), .b(x_reg[0]), .p(x2_t2));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_y2 (
        .clk(clk), .en(en), .a(y_reg[0]), .b(y_reg[0]), .p(y2_t2));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_xy (
        .clk(clk), .en(en), .a(x_reg[0]), .b(y_reg[0]), .p(xy_t2));

    assign r2_t2  = x2_t2 + y2_t2;
    assign dxy_t2 = x2_t2 - y2_t2;

    always_ff @(posedge clk) begin
        if (en) begin
            x2_reg[3]  <= x2_t2;
            y2_reg[3]  <= y2_t2;
            xy_reg[3]  <= xy_t2;
            dxy_reg[3] <= dxy_t2;
            r2_reg[3]  <= r2_t2;
            x2_reg[4]  <= x2_reg[3];
            y2_reg[4]  <= y2_reg[3];
            for (int i = 4; i <= 6; i++) begin
                xy_reg[i]  <= xy_reg[i-1];
                dxy_reg[i] <= dxy_reg[i-1];
            end
            for (int i = 4; i <= 16; i++) begin
                r2_reg[i] <= r2_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // level 2: cubes, fourth powers, mixed terms
    // ------------------------------------------------------------------
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_x3 (
        .clk(clk), .en(en), .a(x2_t2), .b(x_reg[2]), .p(x3_t4));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_y3 (
        .clk(clk), .en(en), .a(y2_t2), .b(y_reg[2]), .p(y3_t4));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_x4 (
        .clk(clk), .en(en), .a(x2_t2), .b(x2_t2), .p(x4_t4));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_y4 (
        .clk(clk), .en(en), .a(y2_t2), .b(y2_t2), .p(y4_t4));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_x2y2 (
        .clk(clk), .en(en), .a(x2_t2), .b(y2_t2), .p(x2y2_t4));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_xy2 (
        .clk(clk), .en(en), .a(x_reg[2]), .b(y2_t2), .p(xy2_t4));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_x2y (
        .clk(clk), .en(en), .a(x2_t2), .b(y_reg[2]), .p(x2y_t4));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_s4p (
        .clk(clk), .en(en), .a(xy_t2), .b(dxy_t2), .p(s4p_t4));

    always_comb begin
        c3_t4  = x3_t4 - xy2_t4 * 3;
        s3_t4  = x2y_t4 * 3 - y3_t4;
        c4_t4  = x4_t4 - x2y2_t4 * 6 + y4_t4;
        s4_t4  = s4p_t4 <<< 2;
        q5c_t4 = x4_t4 - x2y2_t4 * 10 + y4_t4 * 5;
        q5s_t4 = x4_t4 * 5 - x2y2_t4 * 10 + y4_t4;
        q37_t4 = x4_t4 * 6 - x2y2_t4 * 20 + y4_t4 * 6;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            c3_reg[5] <= c3_t4;
            s3_reg[5] <= s3_t4;
            c4_reg[5] <= c4_t4;
            s4_reg[5] <= s4_t4;
            c3_reg[6] <= c3_reg[5];
            s3_reg[6] <= s3_reg[5];
            c4_reg[6] <= c4_reg[5];
            s4_reg[6] <= s4_reg[5];
        end
    end

    // ------------------------------------------------------------------
    // level 3: fifth-order and sixth-order angular parts
    // ------------------------------------------------------------------
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_c5 (
        .clk(clk), .en(en), .a(x_reg[4]), .b(q5c_t4), .p(c5_t6));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_s5 (
        .clk(clk), .en(en), .a(y_reg[4]), .b(q5s_t4), .p(s5_t6));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_t37 (
        .clk(clk), .en(en), .a(xy_reg[4]), .b(q37_t4), .p(t37_t6));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_pa (
        .clk(clk), .en(en), .a(x4_t4), .b(x2_reg[4]), .p(pa_t6));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_pb (
        .clk(clk), .en(en), .a(x4_t4), .b(y2_reg[4]), .p(pb_t6));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_pc (
        .clk(clk), .en(en), .a(x2_reg[4]), .b(y4_t4), .p(pc_t6));
    zct_qmul #(.AW(FW), .BW(FW), .OW(FW)) u_pd (
        .clk(clk), .en(en), .a(y4_t4), .b(y2_reg[4]), .p(pd_t6));

    // factor select for this term
    always_comb begin
        t36_t6 = pa_t6 - pb_t6 * 15 + pc_t6 * 15 - pd_t6;
        ti6    = term_info(op_reg[6]);
        case (ti6.fsel)
            F_ONE:   f_next = FW'(1) <<< QFRAC;
            F_X:     f_next = x_reg[6];
            F_Y:     f_next = y_reg[6];
            F_DXY:   f_next = dxy_reg[6];
            F_XY:    f_next = xy_reg[6];
            F_XY2:   f_next = xy_reg[6] <<< 1;
            F_C3:    f_next = c3_reg[6];
            F_S3:    f_next = s3_reg[6];
            F_C4:    f_next = c4_reg[6];
            F_S4:    f_next = s4_reg[6];
            F_C5:    f_next = c5_t6;
            F_S5:    f_next = s5_t6;
            F_T36:   f_next = t36_t6;
            F_T37:   f_next = t37_t6;
            default: f_next = '0;
        endcase
    end

    always_ff @(posedge clk) begin
        if (en) begin
            f_reg[7] <= f_next;
            for (int i = 8; i <= 18; i++) begin
                f_reg[i] <= f_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // radial polynomial: Horner in r2, one multiplier per tap except the last tap
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= NCOEF - 1; k++) begin : g_horner
        term_info_t           ti;
        logic signed [HW-1:0] acc_in;
        logic signed [FW-1:0] r2_in;

        if (k == 1) begin : g_first
            assign r2_in = r2_t2;
            always_comb begin
                ti     = term_info(op_reg[2*k]);
                acc_in = HW'($signed(ti.coefs[k-1])) <<< QFRAC;
            end
        end else begin : g_next
            assign r2_in = r2_reg[2*k];
            always_comb begin
                ti     = term_info(op_reg[2*k]);
                acc_in = (HW'($signed(ti.coefs[k-1])) <<< QFRAC) + hq[k-1];
            end
        end

        zct_qmul #(.AW(FW), .BW(HW), .OW(HW)) u_tap (
            .clk(clk), .en(en), .a(r2_in), .b(acc_in), .p(hq[k]));
    end

    always_comb begin
        ti18 = term_info(op_reg[18]);
        acc8 = (HW'($signed(ti18.coefs[NCOEF-1])) <<< QFRAC) + hq[NCOEF-1];
    end

    // final product factor * radial
    zct_qmul #(.AW(FW), .BW(HW), .OW(HW)) u_fin (
        .clk(clk), .en(en), .a(f_reg[18]), .b(acc8), .p(v_t20));

    // ------------------------------------------------------------------
    // Q32 -> Q24 round half up, saturate to 48 bits
    // ------------------------------------------------------------------
    always_comb begin
        vr = (v_t20 + HALF8) >>> 8;
        rs = vr[RW-1:0];
        if (rs > OMAX) begin
            res_next = OMAX[OUT_W-1:0];
            sat_next = 1'b1;
        end else if (rs < OMIN) begin
            res_next = OMIN[OUT_W-1:0];
            sat_next = 1'b1;
        end else begin
            res_next = rs[OUT_W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    // ------------------------------------------------------------------
    // output register plus skid entry
    // ------------------------------------------------------------------
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_pipe   = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg && (!out_valid_reg || out_ready)) begin
            load_out_skid   = 1'b1;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end else if (en && vld_reg[21] && (!out_valid_reg || out_ready)) begin
            load_out_pipe  = 1'b1;
            out_valid_next = 1'b1;
        end else if (en && vld_reg[21]) begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load_out_skid) begin
            tv_reg <= skid_tv_reg;
            st_reg <= skid_st_reg;
        end else if (load_out_pipe) begin
            tv_reg <= res_reg;
            st_reg <= sat_reg;
        end
        if (load_skid) begin
            skid_tv_reg <= res_reg;
            skid_st_reg <= sat_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign term_value = tv_reg;
    assign saturated  = st_reg;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for zernike_cartesian_term_eval: a directed table of
// transactions, then random terms and points under three idle patterns, every
// result checked in order against a typed-in value or a bit-exact fixed-point model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zct_pkg::*;

    localparam longint UNIT      = 64'sd1 <<< QFRAC;   // 1.0 in internal format
    localparam longint OUT_HI    = (64'sd1 <<< 47) - 1;
    localparam longint OUT_LO    = -(64'sd1 <<< 47);
    localparam int     IDLE_LIMIT = 3000;              // cycles with no transaction
    localparam int     PHASE_ITEMS = 150;
    localparam int     HOLD_CYCLES = 90;               // long receiver hold-off

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [OP_W-1:0]          opcode;
    logic signed [IN_W-1:0]   x_coord;
    logic signed [IN_W-1:0]   y_coord;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [OUT_W-1:0]  term_value;
    logic                     saturated;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } term_result_t;

    // directed row: chk set means the expected result is typed in here
    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [IN_W-1:0]  x;
        logic signed [IN_W-1:0]  y;
        bit                      chk;
        logic signed [OUT_W-1:0] value;
    } dir_row_t;

    term_result_t pending_terms [$];
    int           mismatches;
    int           idle_cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_request;
    bit           done_sending;

    zernike_cartesian_term_eval uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .term_value (term_value),
        .saturated  (saturated)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------

    // a*b / 2^32, rounded to nearest, ties toward plus infinity
    function automatic longint qmul(input longint a, input longint b);
        logic signed [127:0] p;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        p = p + (128'sd1 <<< 31);
        return p[95:32];
    endfunction

    // Horner in r2, highest coefficient first
    function automatic longint radial(input longint r2, input int n,
                                      input int k0 = 0, input int k1 = 0,
                                      input int k2 = 0, input int k3 = 0,
                                      input int k4 = 0, input int k5 = 0,
                                      input int k6 = 0, input int k7 = 0,
                                      input int k8 = 0);
        int     k [9];
        longint acc;
        k   = '{k0, k1, k2, k3, k4, k5, k6, k7, k8};
        acc = longint'(k[0]) * UNIT;
        for (int i = 1; i < n; i++) begin
            acc = longint'(k[i]) * UNIT + qmul(r2, acc);
        end
        return acc;
    endfunction

    // Q1.INPUT_FRAC_BITS to internal, clamped to +-1
    function automatic longint to_internal(input logic signed [IN_W-1:0] raw);
        longint v;
        v = raw;
        v = v * (64'sd1 <<< (QFRAC - INPUT_FRAC_BITS_DEF));
        if (v > UNIT) v = UNIT;
        if (v < -UNIT) v = -UNIT;
        return v;
    endfunction

    function automatic term_result_t eval_term(input logic [OP_W-1:0] op,
                                               input logic signed [IN_W-1:0] xr,
                                               input logic signed [IN_W-1:0] yr);
        longint x, y, x2, x3, x4, y2, y3, y4, r2, xy, x2y2, dxy;
        longint c3, s3, c4, s4, c5, s5, v, r;
        term_result_t res;
        x    = to_internal(xr);
        y    = to_internal(yr);
        x2   = qmul(x, x);
        x3   = qmul(x2, x);
        x4   = qmul(x2, x2);
        y2   = qmul(y, y);
        y3   = qmul(y2, y);
        y4   = qmul(y2, y2);
        r2   = x2 + y2;
        xy   = qmul(x, y);
        x2y2 = qmul(x2, y2);
        dxy  = x2 - y2;
        c3   = x3 - 3 * qmul(x, y2);
        s3   = 3 * qmul(x2, y) - y3;
        c4   = x4 - 6 * x2y2 + y4;
        s4   = 4 * qmul(xy, dxy);
        c5   = qmul(x, x4 - 10 * x2y2 + 5 * y4);
        s5   = qmul(y, 5 * x4 - 10 * x2y2 + y4);
        case (op)
            ZT_00: v = UNIT;
            ZT_01: v = x;
            ZT_02: v = y;
            ZT_03: v = radial(r2, 2, 2, -1);
            ZT_04: v = dxy;
            ZT_05: v = 2 * xy;
            ZT_06: v = qmul(x, radial(r2, 2, 3, -2));
            ZT_07: v = qmul(y, radial(r2, 2, 3, -2));
            ZT_08: v = radial(r2, 3, 6, -6, 1);
            ZT_09: v = c3;
            ZT_10: v = s3;
            ZT_11: v = qmul(dxy, radial(r2, 2, 4, -3));
            ZT_12: v = qmul(2 * xy, radial(r2, 2, 4, -3));
            ZT_13: v = qmul(x, radial(r2, 3, 10, -12, 3));
            ZT_14: v = qmul(y, radial(r2, 3, 10, -12, 3));
            ZT_15: v = radial(r2, 4, 20, -30, 12, -1);
            ZT_16: v = c4;
            ZT_17: v = s4;
            ZT_18: v = qmul(c3, radial(r2, 2, 5, -4));
            ZT_19: v = qmul(s3, radial(r2, 2, 5, -4));
            ZT_20: v = qmul(dxy, radial(r2, 3, 15, -20, 6));
            ZT_21: v = qmul(2 * xy, radial(r2, 3, 15, -20, 6));
            ZT_22: v = qmul(x, radial(r2, 4, 35, -60, 30, -4));
            ZT_23: v = qmul(y, radial(r2, 4, 35, -60, 30, -4));
            ZT_24: v = radial(r2, 5, 70, -140, 90, -20, 1);
            ZT_25: v = c5;
            ZT_26: v = s5;
            ZT_27: v = qmul(c4, radial(r2, 2, 6, -5));
            ZT_28: v = qmul(s4, radial(r2, 2, 6, -5));
            ZT_29: v = qmul(c3, radial(r2, 3, 21, -30, 10));
            ZT_30: v = qmul(s3, radial(r2, 3, 21, -30, 10));
            ZT_31: v = qmul(dxy, radial(r2, 4, 56, -105, 60, -10));
            ZT_32: v = qmul(xy, radial(r2, 4, 112, -210, 120, -20));
            ZT_33: v = qmul(x, radial(r2, 5, 126, -280, 210, -60, 5));
            ZT_34: v = qmul(y, radial(r2, 5, 126, -280, 210, -60, 5));
            ZT_35: v = radial(r2, 6, 252, -630, 560, -210, 30, -1);
            ZT_36: v = qmul(x4, x2) - 15 * qmul(x4, y2) + 15 * qmul(x2, y4)
                       - qmul(y4, y2);
            ZT_37: v = qmul(xy, 6 * x4 - 20 * x2y2 + 6 * y4);
            ZT_38: v = qmul(c5, radial(r2, 2, 7, -6));
            ZT_39: v = radial(r2, 7, 924, -2772, 3150, -1680, 420, -42, 1);
            ZT_40: v = radial(r2, 8, 3432, -12012, 16632, -11550, 4200, -756,
                              56, -1);
            ZT_41: v = radial(r2, 9, 12870, -51480, 84084, -72072, 34650,
                              -9240, 1260, -72, 1);
            default: v = 0;
        endcase
        // down to 24 fraction bits, round half up, then clamp to 48 bits
        r       = (v + 128) >>> 8;
        res.sat = 1'b0;
        if (r > OUT_HI) begin
            r       = OUT_HI;
            res.sat = 1'b1;
        end else if (r < OUT_LO) begin
            r       = OUT_LO;
            res.sat = 1'b1;
        end
        res.value = r[OUT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // offers one transaction, returns once it has been taken
    task automatic send_point(input logic [OP_W-1:0] op,
                              input logic signed [IN_W-1:0] xr,
                              input logic signed [IN_W-1:0] yr,
                              input bit typed, input logic signed [OUT_W-1:0] tv);
        term_result_t e;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        x_coord  <= xr;
        y_coord  <= yr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (typed) begin
            e.value = tv;
            e.sat   = 1'b0;
        end else begin
            e = eval_term(op, xr, yr);
        end
        pending_terms.push_back(e);
    endtask

    // mix of full-range, boundary and small coordinates
    function automatic logic signed [IN_W-1:0] pick_coord();
        case ($urandom_range(5))
            0: return -24'sd8388608;
            1: return 24'sd8388607;
            2: return 24'($signed($urandom_range(4096)) - 2048);
            3: return 24'($urandom_range(2)) - 24'sd1;
            default: return 24'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    initial begin
        int held;
        held = 0;
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                held         = hold_request;
                hold_request = 0;
            end
            if (held > 0) begin
                out_ready <= 1'b0;
                held--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker, in order against the oldest expectation
    always @(posedge clk) begin
        term_result_t e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_terms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d sat=%0b",
                             term_value, saturated);
            end else begin
                e = pending_terms.pop_front();
                if (term_value !== e.value || saturated !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value=%0d sat=%0b got value=%0d sat=%0b",
                                 e.value, e.sat, term_value, saturated);
                end
            end
        end
    end

    // watchdog: cycles in which neither side moves a transaction
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (rst_n && (!done_sending || pending_terms.size() != 0)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        dir_row_t dir_rows [24];
        int       phase_idle [3][2];

        in_valid       = 1'b0;
        out_ready      = 1'b0;
        opcode         = '0;
        x_coord        = '0;
        y_coord        = '0;
        rst_n          = 1'b0;
        mismatches     = 0;
        idle_cycles    = 0;
        hold_request   = 0;
        done_sending   = 1'b0;
        phase_idle     = '{'{24, 49}, '{49, 24}, '{0, 0}};
        send_idle_pct  = phase_idle[0][0];
        recv_stall_pct = phase_idle[0][1];

        // piston, tilts, one astigmatism term, unknown terms and origin values are typed in;
        // the other terms, mostly at full-scale points, go to the model
        dir_rows = '{
            '{ZT_00, 24'sd0, 24'sd0, 1, 48'sd16777216},
            '{ZT_01, -24'sd8388608, 24'sd0, 1, -48'sd16777216},
            '{ZT_02, 24'sd0, 24'sd8388607, 1, 48'sd16777214},
            '{ZT_03, 24'sd0, 24'sd0, 1, -48'sd16777216},
            '{ZT_04, -24'sd8388608, 24'sd0, 1, 48'sd16777216},
            '{6'd42, 24'sd8388607, 24'sd8388607, 1, 48'sd0},
            '{6'd63, -24'sd8388608, -24'sd8388608, 1, 48'sd0},
            '{6'd50, 24'sd1, -24'sd1, 1, 48'sd0},
            '{ZT_05, 24'sd8388607, 24'sd8388607, 0, 48'sd0},
            '{ZT_08, -24'sd8388608, -24'sd8388608, 0, 48'sd0},
            '{ZT_09, -24'sd8388608, 24'sd8388607, 0, 48'sd0},
            '{ZT_15, 24'sd8388607, -24'sd8388608, 0, 48'sd0},
            '{ZT_17, 24'sd4194304, 24'sd4194304, 0, 48'sd0},
            '{ZT_24, -24'sd8388608, -24'sd8388608, 0, 48'sd0},
            '{ZT_25, 24'sd8388607, 24'sd1, 0, 48'sd0},
            '{ZT_26, -24'sd1, 24'sd8388607, 0, 48'sd0},
            '{ZT_32, 24'sd5931642, 24'sd5931642, 0, 48'sd0},
            '{ZT_35, 24'sd8388607, 24'sd8388607, 0, 48'sd0},
            '{ZT_36, -24'sd8388608, 24'sd8388607, 0, 48'sd0},
            '{ZT_37, 24'sd8388607, -24'sd8388608, 0, 48'sd0},
            '{ZT_38, -24'sd8388608, -24'sd8388608, 0, 48'sd0},
            '{ZT_39, -24'sd8388608, -24'sd8388608, 0, 48'sd0},
            '{ZT_40, 24'sd8388607, 24'sd8388607, 0, 48'sd0},
            '{ZT_41, -24'sd8388608, -24'sd8388608, 0, 48'sd0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_point(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y,
                       dir_rows[i].chk, dir_rows[i].value);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = phase_idle[ph][0];
            recv_stall_pct = phase_idle[ph][1];
            // back-pressure burst: receiver holds while the sender keeps offering
            if (ph == 2) hold_request = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                logic [OP_W-1:0] op;
                // mostly valid term numbers, some unknown ones
                if ($urandom_range(9) == 0) op = 6'($urandom_range(63, 42));
                else op = 6'($urandom_range(41));
                // stretches of back-to-back traffic inside idling phases
                if (n % 50 == 25) begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end else if (n % 50 == 40) begin
                    send_idle_pct  = phase_idle[ph][0];
                    recv_stall_pct = phase_idle[ph][1];
                end
                send_point(op, pick_coord(), pick_coord(), 0, '0);
            end
        end

        in_valid     <= 1'b0;
        done_sending  = 1'b1;
        while (pending_terms.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0 && pending_terms.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
